// ----- src/prm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_pkg: shared types and constants of the running average block
// frame geometry, fixed point weights, queue sizing and channel arithmetic
// ----------------------------------------------------------------------------
package prm_pkg;

  localparam int unsigned FRAME_WIDTH  = 320;
  localparam int unsigned FRAME_HEIGHT = 240;
  localparam int unsigned PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned POS_W        = $clog2(PIX_COUNT);
  localparam int unsigned FILL_W       = $clog2(PIX_COUNT + 1);

  localparam int unsigned CH_W   = 8;
  localparam int unsigned AVG_W  = 24;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned GAIN_W = 6;

  localparam logic [10:0]       W_NEW       = 11'd1311;
  localparam logic [15:0]       W_OLD       = 16'd64225;
  localparam logic [GAIN_W-1:0] MOTION_GAIN = 6'd50;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    MODE_AVERAGE = 1'b0,
    MODE_MOTION  = 1'b1
  } mode_e;

  typedef logic [POS_W-1:0]            pos_t;
  typedef logic [AVG_W-1:0]            avg_t;
  typedef logic [2:0][CH_W-1:0]        rgb_t;
  typedef logic [2:0][AVG_W-1:0]       avg_px_t;

  // lane 2 red, lane 1 green, lane 0 blue
  typedef struct packed {
    pos_t pos;
    logic last;
    rgb_t pix;
  } item_t;

  function automatic avg_t blend(logic [CH_W-1:0] x, avg_t old);
    logic [AVG_W+FRAC_W-1:0] prod_old;
    avg_t                    part_new;
    prod_old = (AVG_W + FRAC_W)'(old) * (AVG_W + FRAC_W)'(W_OLD);
    part_new = AVG_W'(x) * AVG_W'(W_NEW);
    return part_new + prod_old[AVG_W+FRAC_W-1:FRAC_W];
  endfunction

  function automatic logic [CH_W-1:0] motion(avg_t nv, avg_t old);
    avg_t                          diff;
    logic [AVG_W+GAIN_W-1:0]       prod;
    logic [AVG_W+GAIN_W-FRAC_W-1:0] scaled;
    diff   = (nv >= old) ? (nv - old) : (old - nv);
    prod   = (AVG_W + GAIN_W)'(diff) * (AVG_W + GAIN_W)'(MOTION_GAIN);
    scaled = prod[AVG_W+GAIN_W-1:FRAC_W];
    return (scaled > (AVG_W + GAIN_W - FRAC_W)'(255)) ? {CH_W{1'b1}} : scaled[CH_W-1:0];
  endfunction

endpackage

// ----- src/prm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_if: channel interfaces of the running average block
// pixel input, result output and mode register write channels
// ----------------------------------------------------------------------------
interface prm_pix_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

interface prm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_of_frame;

  modport source (output valid, red_out, green_out, blue_out, last_of_frame, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

interface prm_cfg_if;
  logic valid;
  logic ready;
  logic output_mode;

  modport source (output valid, output_mode, input ready);
  modport sink   (input valid, output_mode, output ready);
endinterface

// ----- src/prm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_front: pixel intake and position tracking
// tags each accepted pixel with its frame position and end of frame flag
// ----------------------------------------------------------------------------
module prm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  prm_pix_if.sink        in_i,
  input  logic           q_full_i,
  output logic           push_o,
  output prm_pkg::item_t item_o
);

  prm_pkg::pos_t pos_q, pos_d;
  prm_pkg::pos_t pos_cur;
  logic          last;

  always_comb begin
    pos_cur    = in_i.frame_start ? '0 : pos_q;
    last       = (pos_cur == prm_pkg::POS_W'(prm_pkg::PIX_COUNT - 1));
    in_i.ready = !q_full_i;
    push_o     = in_i.valid && !q_full_i;
    item_o.pos = pos_cur;
    item_o.last = last;
    item_o.pix = {in_i.red_in, in_i.green_in, in_i.blue_in};
    pos_d      = pos_q;
    if (push_o) begin
      pos_d = last ? '0 : pos_cur + prm_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- src/prm_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_fifo: short queue between intake and update pipeline
// lets either side stall without holding up the other
// ----------------------------------------------------------------------------
module prm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  prm_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  output prm_pkg::item_t item_o,
  input  logic           pop_i
);

  prm_pkg::item_t                mem_q [prm_pkg::QUEUE_DEPTH];
  logic [prm_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [prm_pkg::QCNT_W-1:0]    cnt_q, cnt_d;

  always_comb begin
    full_o  = (cnt_q == prm_pkg::QCNT_W'(prm_pkg::QUEUE_DEPTH));
    valid_o = (cnt_q != '0);
    item_o  = mem_q[rd_ptr_q];
    cnt_d   = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + prm_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - prm_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + prm_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + prm_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/prm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_back: average store update pipeline
// reads the stored average, blends in the new pixel, writes it back and
// forms the average or motion result
// ----------------------------------------------------------------------------
module prm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  prm_pkg::item_t item_i,
  output logic           pop_o,
  input  prm_pkg::mode_e mode_i,
  prm_res_if.source      out_o
);

  prm_pkg::avg_px_t mem_q [prm_pkg::PIX_COUNT];
  prm_pkg::avg_px_t ram_q;

  logic                       b1_vld_q, b2_vld_q, out_vld_q;
  logic                       b1_free, b2_free, out_adv, wr_en;
  prm_pkg::item_t             b1_item_q;
  prm_pkg::avg_px_t           b1_old, b1_new;
  prm_pkg::avg_px_t           b2_new_q, b2_old_q;
  logic                       b2_last_q;
  prm_pkg::rgb_t              out_pix_q, out_pix_d;
  logic                       out_last_q;

  // last write, forwarded to the next reader of the same position
  logic                       wr_vld_q;
  prm_pkg::pos_t              wr_pos_q;
  prm_pkg::avg_px_t           wr_data_q;
  // positions below the fill count have been written since reset
  logic [prm_pkg::FILL_W-1:0] fill_q, fill_d;

  always_comb begin
    out_adv = !out_vld_q || out_o.ready;
    b2_free = !b2_vld_q || out_adv;
    b1_free = !b1_vld_q || b2_free;
    pop_o   = q_valid_i && b1_free;
    wr_en   = b1_vld_q && b2_free;
  end

  always_comb begin
    if (wr_vld_q && (wr_pos_q == b1_item_q.pos)) begin
      b1_old = wr_data_q;
    end else if (prm_pkg::FILL_W'(b1_item_q.pos) < fill_q) begin
      b1_old = ram_q;
    end else begin
      b1_old = '0;
    end
    for (int l = 0; l < 3; l++) begin
      b1_new[l] = prm_pkg::blend(b1_item_q.pix[l], b1_old[l]);
    end
    fill_d = fill_q;
    if (wr_en && (prm_pkg::FILL_W'(b1_item_q.pos) >= fill_q)) begin
      fill_d = prm_pkg::FILL_W'(b1_item_q.pos) + prm_pkg::FILL_W'(1);
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      case (mode_i)
        prm_pkg::MODE_MOTION: out_pix_d[l] = prm_pkg::motion(b2_new_q[l], b2_old_q[l]);
        default:              out_pix_d[l] = b2_new_q[l][prm_pkg::AVG_W-1:prm_pkg::FRAC_W];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      wr_vld_q  <= 1'b0;
      fill_q    <= '0;
    end else begin
      fill_q <= fill_d;
      if (b1_free) begin
        b1_vld_q <= pop_o;
      end
      if (b2_free) begin
        b2_vld_q <= b1_vld_q;
      end
      if (out_adv) begin
        out_vld_q <= b2_vld_q;
      end
      if (wr_en) begin
        wr_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_item_q <= item_i;
    end
    if (wr_en) begin
      wr_pos_q  <= b1_item_q.pos;
      wr_data_q <= b1_new;
    end
    if (b2_free) begin
      b2_new_q  <= b1_new;
      b2_old_q  <= b1_old;
      b2_last_q <= b1_item_q.last;
    end
    if (out_adv) begin
      out_pix_q  <= out_pix_d;
      out_last_q <= b2_last_q;
    end
  end

  // frame store, one write and one read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[b1_item_q.pos] <= b1_new;
    end
    if (pop_o) begin
      ram_q <= mem_q[item_i.pos];
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.red_out       = out_pix_q[2];
  assign out_o.green_out     = out_pix_q[1];
  assign out_o.blue_out      = out_pix_q[0];
  assign out_o.last_of_frame = out_last_q;

endmodule

// ----- src/pixel_running_average_motion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_running_average_motion: per pixel running average with motion output
// path: queue, stage b1, stage b2, then the output register to result valid
// throughput: one pixel per cycle while the result output is not stalled,
//   set by the separate read and write ports of the frame store
// reset: no clearing pass; a fill count treats never written positions
//   as zero, so pixels are taken from the first cycle after reset
// ----------------------------------------------------------------------------
module pixel_running_average_motion (
  input  logic      clk_i,
  input  logic      rst_ni,
  prm_pix_if.sink   in_i,
  prm_res_if.source out_o,
  prm_cfg_if.sink   cfg_i
);

  logic           push, q_full, q_valid, pop;
  prm_pkg::item_t push_item, pop_item;
  prm_pkg::mode_e mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= prm_pkg::MODE_AVERAGE;
    end else if (cfg_i.valid) begin
      mode_q <= prm_pkg::mode_e'(cfg_i.output_mode);
    end
  end

  prm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  prm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (pop_item),
    .pop_i   (pop)
  );

  prm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .item_i    (pop_item),
    .pop_o     (pop),
    .mode_i    (mode_q),
    .out_o     (out_o)
  );

endmodule

// ----- src/prm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_checker: port level checks of the running average block
// tracks pixels in flight from the transfers seen at the ports
// ----------------------------------------------------------------------------
module prm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       last_i,
  input logic       cfg_valid_i,
  input logic       cfg_ready_i
);

  localparam logic [3:0] MAX_IN_FLIGHT = 4'(prm_pkg::QUEUE_DEPTH + 3);

  logic       in_xfer, out_xfer;
  logic [3:0] cnt_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      cnt_q <= cnt_q + 4'd1;
    end else if (out_xfer && !in_xfer) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> cnt_q != 4'd0)
    else $error("result transfer without a pixel in flight");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_IN_FLIGHT)
    else $error("more pixels in flight than the pipeline holds");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> cnt_q >= 4'(prm_pkg::QUEUE_DEPTH))
    else $error("input stalled while the queue has room");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("mode write not taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({red_i, green_i, blue_i, last_i}))
    else $error("stalled result changed");

endmodule

bind pixel_running_average_motion prm_checker u_prm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red_out),
  .green_i     (out_o.green_out),
  .blue_i      (out_o.blue_out),
  .last_i      (out_o.last_of_frame),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
